@@ hw/rtl/ssp_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the sprite screen projection pipeline.
// Depends on nothing; every other file of the block imports it.
package ssp_pkg;

  localparam int FRAC_BITS = 16;

  // Coordinate and intermediate widths.
  localparam int CRD_W   = 32;
  localparam int REL_W   = CRD_W + 1;
  localparam int PRD_W   = REL_W + CRD_W;
  localparam int DP_W    = 2 * CRD_W;
  localparam int DET_W   = DP_W + 1;
  localparam int NUM_W   = PRD_W + 1;
  localparam int SUM_W   = NUM_W + 1;
  localparam int NYM_W   = NUM_W - 1;
  localparam int SM_W    = SUM_W - 1;
  localparam int DETM_W  = DET_W - 1;
  localparam int DIM_W   = 13;
  localparam int W2_W    = DIM_W - 1;
  localparam int SL_W    = (SM_W + 1) / 2;
  localparam int SH_W    = SM_W - SL_W;
  localparam int PP_W    = W2_W + SL_W;
  localparam int PPH_W   = W2_W + SH_W;
  localparam int NUMER_W = PPH_W + SL_W;
  localparam int NUMA_W  = NYM_W + FRAC_BITS;
  localparam int HS_W    = DIM_W + FRAC_BITS;

  // Quotient bits produced by each divider.
  localparam int DEP_Q = 32;
  localparam int CEN_Q = 18;
  localparam int SIZ_Q = 16;

  // Divider lane widths.
  localparam int LN_W  = DEP_Q;
  localparam int R_W   = NYM_W;
  localparam int CNT_W = $clog2(LN_W + 1);

  // Output widths.
  localparam int CEN_W  = 18;
  localparam int SIZE_W = 16;
  localparam int ROW_W  = 12;
  localparam int CS_W   = 17;
  localparam int CE_W   = 18;

  localparam logic [LN_W-1:0]  DEP_LIM_POS = {1'b0, {(LN_W-1){1'b1}}};
  localparam logic [LN_W-1:0]  DEP_LIM_NEG = {1'b1, {(LN_W-1){1'b0}}};
  localparam logic [CEN_Q-1:0] CEN_LIM_POS = {1'b0, {(CEN_Q-1){1'b1}}};
  localparam logic [CEN_Q-1:0] CEN_LIM_NEG = {1'b1, {(CEN_Q-1){1'b0}}};

  typedef enum logic [2:0] {
    REG_CAMERA_X      = 3'd0,
    REG_CAMERA_Y      = 3'd1,
    REG_DIR_X         = 3'd2,
    REG_DIR_Y         = 3'd3,
    REG_PLANE_X       = 3'd4,
    REG_PLANE_Y       = 3'd5,
    REG_SCREEN_WIDTH  = 3'd6,
    REG_SCREEN_HEIGHT = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [CRD_W-1:0] camera_x;
    logic [CRD_W-1:0] camera_y;
    logic [CRD_W-1:0] dir_x;
    logic [CRD_W-1:0] dir_y;
    logic [CRD_W-1:0] plane_x;
    logic [CRD_W-1:0] plane_y;
    logic [DIM_W-1:0] screen_width;
    logic [DIM_W-1:0] screen_height;
  } cfg_t;

  // One restoring-division lane: partial remainder, divisor, dividend bits
  // still to shift in (MSB first), quotient so far, steps left.
  typedef struct packed {
    logic [R_W-1:0]   rem;
    logic [R_W-1:0]   den;
    logic [LN_W-1:0]  num;
    logic [LN_W-1:0]  quo;
    logic [CNT_W-1:0] cnt;
  } lane_t;

  typedef struct packed {
    logic             a_ovf;
    logic             a_neg;
    logic             det_zero;
    logic             b_ovf;
    logic             b_neg;
    logic             c_ovf;
    logic             degen;
    logic [CRD_W-1:0] depth;
  } side_t;

  typedef struct packed {
    lane_t a;
    lane_t b;
    side_t side;
  } item_t;

endpackage

@@ hw/rtl/sprite_screen_projection.sv @@
`timescale 1ns / 1ps
// Sprite screen projection top level: configuration registers and pipeline.
// Depends on ssp_pkg, ssp_front, ssp_cell, ssp_mid and ssp_back.

// This block takes one sprite world position per transaction and returns its
// depth, centre column, projected size and drawing bounds. It accepts one
// transaction every clock cycle and returns one result per cycle while
// out_ready_i is high. Each transaction passes through six front-end
// stages (offset, products, cross terms, magnitudes, two setup stages), a row
// of 32 divider cells that produce the depth one quotient bit per cell while
// also producing the 18 bits of the centre column, one depth saturation
// stage, a row of 16 cells for the sprite size, and the output register.
// Each cell stalls only when the cell after it holds a transaction that is
// not moving, so the pipeline keeps filling while a result waits at the
// output. Configuration registers are read directly by the front, mid and
// back stages and must be written only while no transaction is in flight.
module sprite_screen_projection (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [31:0]        sprite_x_i,
  input  logic [31:0]        sprite_y_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] depth_o,
  output logic signed [17:0] center_column_o,
  output logic [15:0]        sprite_size_o,
  output logic [11:0]        row_start_o,
  output logic [11:0]        row_end_o,
  output logic [16:0]        col_start_o,
  output logic signed [17:0] col_end_o,
  output logic               in_front_o,
  output logic               degenerate_o
);
  import ssp_pkg::*;

  // Configuration registers, reset to a camera at the origin looking along
  // +x with a plane of about 0.66 and a 640 by 480 screen.
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.camera_x      <= '0;
      cfg_q.camera_y      <= '0;
      cfg_q.dir_x         <= CRD_W'(65536);
      cfg_q.dir_y         <= '0;
      cfg_q.plane_x       <= '0;
      cfg_q.plane_y       <= CRD_W'(43253);
      cfg_q.screen_width  <= DIM_W'(640);
      cfg_q.screen_height <= DIM_W'(480);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CAMERA_X:      cfg_q.camera_x      <= cfg_data_i;
        REG_CAMERA_Y:      cfg_q.camera_y      <= cfg_data_i;
        REG_DIR_X:         cfg_q.dir_x         <= cfg_data_i;
        REG_DIR_Y:         cfg_q.dir_y         <= cfg_data_i;
        REG_PLANE_X:       cfg_q.plane_x       <= cfg_data_i;
        REG_PLANE_Y:       cfg_q.plane_y       <= cfg_data_i;
        REG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_data_i[DIM_W-1:0];
        REG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_data_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // First row of cells: depth division on lane a, centre division on lane b.
  item_t c1_item  [DEP_Q+1];
  logic  c1_valid [DEP_Q+1];
  logic  c1_ready [DEP_Q+1];

  ssp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .sprite_x_i  (sprite_x_i),
    .sprite_y_i  (sprite_y_i),
    .out_valid_o (c1_valid[0]),
    .out_ready_i (c1_ready[0]),
    .out_item_o  (c1_item[0])
  );

  for (genvar i = 0; i < DEP_Q; i++) begin : g_dep_cell
    ssp_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (c1_valid[i]),
      .in_ready_o  (c1_ready[i]),
      .in_item_i   (c1_item[i]),
      .out_valid_o (c1_valid[i+1]),
      .out_ready_i (c1_ready[i+1]),
      .out_item_o  (c1_item[i+1])
    );
  end

  // Depth is saturated here and lane a is reloaded for the size division.
  item_t c2_item  [SIZ_Q+1];
  logic  c2_valid [SIZ_Q+1];
  logic  c2_ready [SIZ_Q+1];

  ssp_mid u_mid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (c1_valid[DEP_Q]),
    .in_ready_o  (c1_ready[DEP_Q]),
    .in_item_i   (c1_item[DEP_Q]),
    .out_valid_o (c2_valid[0]),
    .out_ready_i (c2_ready[0]),
    .out_item_o  (c2_item[0])
  );

  for (genvar i = 0; i < SIZ_Q; i++) begin : g_siz_cell
    ssp_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (c2_valid[i]),
      .in_ready_o  (c2_ready[i]),
      .in_item_i   (c2_item[i]),
      .out_valid_o (c2_valid[i+1]),
      .out_ready_i (c2_ready[i+1]),
      .out_item_o  (c2_item[i+1])
    );
  end

  ssp_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .in_valid_i      (c2_valid[SIZ_Q]),
    .in_ready_o      (c2_ready[SIZ_Q]),
    .in_item_i       (c2_item[SIZ_Q]),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .depth_o         (depth_o),
    .center_column_o (center_column_o),
    .sprite_size_o   (sprite_size_o),
    .row_start_o     (row_start_o),
    .row_end_o       (row_end_o),
    .col_start_o     (col_start_o),
    .col_end_o       (col_end_o),
    .in_front_o      (in_front_o),
    .degenerate_o    (degenerate_o)
  );

  // A degenerate result is never in front and has no size.
  a_degen_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |-> !in_front_o && sprite_size_o == '0 &&
                                    center_column_o == '0)
    else $error("degenerate result carries a size or centre");

  // A sprite in front has a strictly positive depth.
  a_front_depth : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && in_front_o |-> !depth_o[31] && depth_o != '0)
    else $error("in_front set without positive depth");

  // The row span never turns inside out.
  a_row_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> row_start_o <= row_end_o)
    else $error("row_start above row_end");

endmodule

@@ hw/rtl/ssp_front.sv @@
`timescale 1ns / 1ps
// Front end: camera offset, matrix products, magnitudes and divider setup.
// Depends on ssp_pkg.
module ssp_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ssp_pkg::cfg_t cfg_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [31:0]   sprite_x_i,
  input  logic [31:0]   sprite_y_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ssp_pkg::item_t out_item_o
);
  import ssp_pkg::*;

  localparam int NSTG = 6;

  logic [NSTG-1:0] v_q, v_d;
  logic [NSTG:0]   rdy;

  always_comb begin
    rdy[NSTG] = out_ready_i;
    for (int k = NSTG - 1; k >= 0; k--) begin
      rdy[k] = ~v_q[k] | rdy[k+1];
    end
    v_d[0] = rdy[0] ? in_valid_i : v_q[0];
    for (int k = 1; k < NSTG; k++) begin
      v_d[k] = rdy[k] ? v_q[k-1] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[NSTG-1];

  // Stage 1: position relative to the camera.
  logic signed [REL_W-1:0] rx_q, ry_q, rx_d, ry_d;
  assign rx_d = $signed({sprite_x_i[CRD_W-1], sprite_x_i})
              - $signed({cfg_i.camera_x[CRD_W-1], cfg_i.camera_x});
  assign ry_d = $signed({sprite_y_i[CRD_W-1], sprite_y_i})
              - $signed({cfg_i.camera_y[CRD_W-1], cfg_i.camera_y});

  // Stage 2: products.
  logic signed [PRD_W-1:0] p_dyrx_q, p_dxry_q, p_pxry_q, p_pyrx_q;
  logic signed [DP_W-1:0]  p_pxdy_q, p_dxpy_q;

  // Stage 3: cross terms and determinant.
  logic signed [NUM_W-1:0] nx_q, ny_q;
  logic signed [DET_W-1:0] det_q;

  // Stage 4: magnitudes and signs.
  logic signed [SUM_W-1:0] s_full;
  logic [SUM_W-1:0]        s_abs;
  logic [NUM_W-1:0]        ny_abs;
  logic [DET_W-1:0]        det_abs;
  logic [NYM_W-1:0]        ny_mag_q;
  logic [SM_W-1:0]         s_mag_q;
  logic [DETM_W-1:0]       det_mag_q;
  logic                    a_neg_q, b_neg_q, det_zero_q;

  always_comb begin
    s_full  = $signed({nx_q[NUM_W-1], nx_q}) + $signed({ny_q[NUM_W-1], ny_q});
    s_abs   = s_full[SUM_W-1] ? SUM_W'(-s_full) : SUM_W'(s_full);
    ny_abs  = ny_q[NUM_W-1] ? NUM_W'(-ny_q) : NUM_W'(ny_q);
    det_abs = det_q[DET_W-1] ? DET_W'(-det_q) : DET_W'(det_q);
  end

  // Stage 5: center numerator partial products and depth lane setup.
  logic [W2_W-1:0]          w2;
  logic [NUMA_W-1:0]        numa;
  logic [NUMA_W-DEP_Q-1:0]  a_hi;
  lane_t                    lane_a_d;
  logic [PP_W-1:0]          pl_q;
  logic [PPH_W-1:0]         ph_q;
  logic [NYM_W-1:0]         ny_mag5_q;
  lane_t                    lane_a_q;
  logic                     a_ovf_q, a_neg5_q, b_neg5_q, det_zero5_q;

  always_comb begin
    w2   = cfg_i.screen_width[DIM_W-1:1];
    numa = {ny_mag_q, {FRAC_BITS{1'b0}}};
    a_hi = numa[NUMA_W-1:DEP_Q];
    lane_a_d.rem = R_W'(a_hi);
    lane_a_d.den = R_W'(det_mag_q);
    lane_a_d.num = numa[DEP_Q-1:0];
    lane_a_d.quo = '0;
    lane_a_d.cnt = CNT_W'(DEP_Q);
  end

  // Stage 6: center lane setup.
  logic [NUMER_W-1:0]       numer;
  logic [NUMER_W-CEN_Q-1:0] b_hi;
  item_t                    item_d, item_q;

  always_comb begin
    numer = {ph_q, {SL_W{1'b0}}} + NUMER_W'(pl_q);
    b_hi  = numer[NUMER_W-1:CEN_Q];
    item_d.a            = lane_a_q;
    item_d.b.rem        = R_W'(b_hi);
    item_d.b.den        = R_W'(ny_mag5_q);
    item_d.b.num        = {numer[CEN_Q-1:0], {(LN_W-CEN_Q){1'b0}}};
    item_d.b.quo        = '0;
    item_d.b.cnt        = CNT_W'(CEN_Q);
    item_d.side.a_ovf   = a_ovf_q;
    item_d.side.a_neg   = a_neg5_q;
    item_d.side.det_zero = det_zero5_q;
    item_d.side.b_ovf   = (R_W'(b_hi) >= R_W'(ny_mag5_q));
    item_d.side.b_neg   = b_neg5_q;
    item_d.side.c_ovf   = 1'b0;
    item_d.side.degen   = 1'b0;
    item_d.side.depth   = '0;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      rx_q <= rx_d;
      ry_q <= ry_d;
    end
    if (rdy[1]) begin
      p_dyrx_q <= rx_q * $signed(cfg_i.dir_y);
      p_dxry_q <= ry_q * $signed(cfg_i.dir_x);
      p_pxry_q <= ry_q * $signed(cfg_i.plane_x);
      p_pyrx_q <= rx_q * $signed(cfg_i.plane_y);
      p_pxdy_q <= $signed(cfg_i.plane_x) * $signed(cfg_i.dir_y);
      p_dxpy_q <= $signed(cfg_i.dir_x) * $signed(cfg_i.plane_y);
    end
    if (rdy[2]) begin
      nx_q  <= $signed({p_dyrx_q[PRD_W-1], p_dyrx_q}) - $signed({p_dxry_q[PRD_W-1], p_dxry_q});
      ny_q  <= $signed({p_pxry_q[PRD_W-1], p_pxry_q}) - $signed({p_pyrx_q[PRD_W-1], p_pyrx_q});
      det_q <= $signed({p_pxdy_q[DP_W-1], p_pxdy_q}) - $signed({p_dxpy_q[DP_W-1], p_dxpy_q});
    end
    if (rdy[3]) begin
      ny_mag_q   <= ny_abs[NYM_W-1:0];
      s_mag_q    <= s_abs[SM_W-1:0];
      det_mag_q  <= det_abs[DETM_W-1:0];
      a_neg_q    <= ny_q[NUM_W-1] ^ det_q[DET_W-1];
      b_neg_q    <= s_full[SUM_W-1] ^ ny_q[NUM_W-1];
      det_zero_q <= (det_q == '0);
    end
    if (rdy[4]) begin
      pl_q        <= w2 * s_mag_q[SL_W-1:0];
      ph_q        <= w2 * s_mag_q[SM_W-1:SL_W];
      ny_mag5_q   <= ny_mag_q;
      lane_a_q    <= lane_a_d;
      a_ovf_q     <= (R_W'(a_hi) >= R_W'(det_mag_q));
      a_neg5_q    <= a_neg_q;
      b_neg5_q    <= b_neg_q;
      det_zero5_q <= det_zero_q;
    end
    if (rdy[5]) begin
      item_q <= item_d;
    end
  end

  assign out_item_o = item_q;

endmodule

@@ hw/rtl/ssp_cell.sv @@
`timescale 1ns / 1ps
// One divider cell: a restoring step on each lane that still has steps left.
// Depends on ssp_pkg.
module ssp_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ssp_pkg::item_t in_item_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output ssp_pkg::item_t out_item_o
);
  import ssp_pkg::*;

  function automatic lane_t lane_step(lane_t l);
    lane_t        r;
    logic [R_W:0] trial;
    logic [R_W:0] diff;
    r     = l;
    trial = {l.rem, l.num[LN_W-1]};
    diff  = trial - {1'b0, l.den};
    if (l.cnt != '0) begin
      if (trial >= {1'b0, l.den}) begin
        r.rem = diff[R_W-1:0];
        r.quo = {l.quo[LN_W-2:0], 1'b1};
      end else begin
        r.rem = trial[R_W-1:0];
        r.quo = {l.quo[LN_W-2:0], 1'b0};
      end
      r.num = {l.num[LN_W-2:0], 1'b0};
      r.cnt = l.cnt - 1'b1;
    end
    return r;
  endfunction

  logic  valid_q;
  item_t item_q, item_d;

  assign in_ready_o = ~valid_q | out_ready_i;

  always_comb begin
    item_d   = in_item_i;
    item_d.a = lane_step(in_item_i.a);
    item_d.b = lane_step(in_item_i.b);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      item_q <= item_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

@@ hw/rtl/ssp_mid.sv @@
`timescale 1ns / 1ps
// Depth saturation and setup of the sprite size division.
// Depends on ssp_pkg.
module ssp_mid (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ssp_pkg::cfg_t  cfg_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ssp_pkg::item_t in_item_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output ssp_pkg::item_t out_item_o
);
  import ssp_pkg::*;

  logic              valid_q;
  item_t             item_q, item_d;
  logic [LN_W-1:0]   lim, mag;
  logic [HS_W-1:0]   hs;
  logic [HS_W-SIZ_Q-1:0] c_hi;

  assign in_ready_o = ~valid_q | out_ready_i;

  always_comb begin
    lim = in_item_i.side.a_neg ? DEP_LIM_NEG : DEP_LIM_POS;
    if (in_item_i.side.det_zero) begin
      mag = '0;
    end else if (in_item_i.side.a_ovf || (in_item_i.a.quo > lim)) begin
      mag = lim;
    end else begin
      mag = in_item_i.a.quo;
    end
    hs   = {cfg_i.screen_height, {FRAC_BITS{1'b0}}};
    c_hi = hs[HS_W-1:SIZ_Q];

    item_d            = in_item_i;
    item_d.side.depth = in_item_i.side.a_neg ? CRD_W'(-mag) : CRD_W'(mag);
    item_d.side.degen = (mag == '0);
    item_d.side.c_ovf = (LN_W'(c_hi) >= mag);
    item_d.a.rem      = R_W'(c_hi);
    item_d.a.den      = R_W'(mag);
    item_d.a.num      = {hs[SIZ_Q-1:0], {(LN_W-SIZ_Q){1'b0}}};
    item_d.a.quo      = '0;
    item_d.a.cnt      = CNT_W'(SIZ_Q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      item_q <= item_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

@@ hw/rtl/ssp_back.sv @@
`timescale 1ns / 1ps
// Output stage: center and size saturation, drawing bounds, result register.
// Depends on ssp_pkg.
module ssp_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ssp_pkg::cfg_t          cfg_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  ssp_pkg::item_t         in_item_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic signed [31:0]     depth_o,
  output logic signed [17:0]     center_column_o,
  output logic [15:0]            sprite_size_o,
  output logic [11:0]            row_start_o,
  output logic [11:0]            row_end_o,
  output logic [16:0]            col_start_o,
  output logic signed [17:0]     col_end_o,
  output logic                   in_front_o,
  output logic                   degenerate_o
);
  import ssp_pkg::*;

  logic                      valid_q;
  logic [CEN_Q-1:0]          qb, limb, magb;
  logic signed [CEN_W-1:0]   center;
  logic [SIZE_W-1:0]         size;
  logic [SIZE_W-2:0]         half;
  logic [ROW_W-1:0]          hh;
  logic [DIM_W-1:0]          h, w;
  logic signed [SIZE_W:0]    rs_t;
  logic [SIZE_W:0]           re_t;
  logic signed [DIM_W:0]     h_m1;
  logic signed [SIZE_W+1:0]  re_s;
  logic signed [CEN_W:0]     cs_t, ce_t, w_s, w_m1, ce_s;
  logic [ROW_W-1:0]          rs, re;
  logic [CS_W-1:0]           cs;
  logic                      degen;

  assign in_ready_o = ~valid_q | out_ready_i;

  always_comb begin
    degen = in_item_i.side.degen;
    h     = cfg_i.screen_height;
    w     = cfg_i.screen_width;
    qb    = in_item_i.b.quo[CEN_Q-1:0];
    limb  = in_item_i.side.b_neg ? CEN_LIM_NEG : CEN_LIM_POS;
    magb  = (in_item_i.side.b_ovf || (qb > limb)) ? limb : qb;
    if (degen) begin
      center = '0;
      size   = '0;
    end else begin
      center = in_item_i.side.b_neg ? CEN_W'(-magb) : CEN_W'(magb);
      size   = in_item_i.side.c_ovf ? {SIZE_W{1'b1}} : in_item_i.a.quo[SIZE_W-1:0];
    end
    half = size[SIZE_W-1:1];
    hh   = h[DIM_W-1:1];

    rs_t = $signed({{(SIZE_W+1-ROW_W){1'b0}}, hh}) - $signed({2'b00, half});
    rs   = rs_t[SIZE_W] ? '0 : rs_t[ROW_W-1:0];

    re_t = {{(SIZE_W+1-ROW_W){1'b0}}, hh} + {2'b00, half};
    h_m1 = $signed({1'b0, h}) - $signed({{DIM_W{1'b0}}, 1'b1});
    if (re_t >= {{(SIZE_W+1-DIM_W){1'b0}}, h}) begin
      re_s = {{(SIZE_W+1-DIM_W){h_m1[DIM_W]}}, h_m1};
    end else begin
      re_s = $signed({1'b0, re_t});
    end
    if (re_s[SIZE_W+1]) begin
      re = '0;
    end else if (re_s > $signed({{(SIZE_W+2-ROW_W){1'b0}}, {ROW_W{1'b1}}})) begin
      re = {ROW_W{1'b1}};
    end else begin
      re = re_s[ROW_W-1:0];
    end

    cs_t = $signed({center[CEN_W-1], center}) - $signed({{(CEN_W+2-SIZE_W){1'b0}}, half});
    cs   = cs_t[CEN_W] ? '0 : cs_t[CS_W-1:0];

    ce_t = $signed({center[CEN_W-1], center}) + $signed({{(CEN_W+2-SIZE_W){1'b0}}, half});
    w_s  = $signed({{(CEN_W+1-DIM_W){1'b0}}, w});
    w_m1 = w_s - $signed({{CEN_W{1'b0}}, 1'b1});
    ce_s = (ce_t >= w_s) ? w_m1 : ce_t;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      depth_o         <= in_item_i.side.depth;
      center_column_o <= center;
      sprite_size_o   <= size;
      row_start_o     <= rs;
      row_end_o       <= re;
      col_start_o     <= cs;
      col_end_o       <= ce_s[CE_W-1:0];
      in_front_o      <= ~degen & ~in_item_i.side.depth[CRD_W-1];
      degenerate_o    <= degen;
    end
  end

  assign out_valid_o = valid_q;

endmodule
